### hw/rtl/bkcd_pkg.sv
`default_nettype none

package bkcd_pkg;

    localparam int KEY_W   = 15;
    localparam int CMD_W   = 6;
    localparam int POS_W   = 7;
    localparam int TICK_W  = 8;
    localparam int GRP_W   = 2;

    localparam logic [TICK_W-1:0] DELAY_RESET    = 8'd10;
    localparam logic [TICK_W-1:0] INTERVAL_RESET = 8'd2;

    // configuration register indexes
    localparam logic CFG_DELAY    = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    // group selection left by the previous byte
    localparam logic [GRP_W-1:0] GRP_NONE  = 2'd0;
    localparam logic [GRP_W-1:0] GRP_OP    = 2'd1;
    localparam logic [GRP_W-1:0] GRP_ROUTE = 2'd2;

    localparam logic [7:0] BYTE_GRP_OP    = 8'h71;
    localparam logic [7:0] BYTE_GRP_ROUTE = 8'h72;
    localparam logic [7:0] BYTE_ROUTE_MAX = 8'h5F;
    localparam logic [7:0] BYTE_OP_MAKE_MAX  = 8'h09;
    localparam logic [7:0] BYTE_ST_MAKE_MIN  = 8'h20;
    localparam logic [7:0] BYTE_ST_MAKE_MAX  = 8'h25;
    localparam logic [7:0] BYTE_OP_BREAK_MIN = 8'h80;
    localparam logic [7:0] BYTE_OP_BREAK_MAX = 8'h89;
    localparam logic [7:0] BYTE_ST_BREAK_MIN = 8'hA0;
    localparam logic [7:0] BYTE_ST_BREAK_MAX = 8'hA5;

    // key bits
    localparam logic [KEY_W-1:0] K_UP      = 15'h0001;
    localparam logic [KEY_W-1:0] K_CURSOR  = 15'h0002;
    localparam logic [KEY_W-1:0] K_HOME    = 15'h0004;
    localparam logic [KEY_W-1:0] K_PROG    = 15'h0008;
    localparam logic [KEY_W-1:0] K_LEFT    = 15'h0010;
    localparam logic [KEY_W-1:0] K_RIGHT   = 15'h0020;
    localparam logic [KEY_W-1:0] K_DOWN    = 15'h0040;
    localparam logic [KEY_W-1:0] K_CURSOR2 = 15'h0080;
    localparam logic [KEY_W-1:0] K_HOME2   = 15'h0100;
    localparam logic [KEY_W-1:0] K_PROG2   = 15'h0200;
    localparam logic [KEY_W-1:0] K_ROUTE   = 15'h0400;
    localparam logic [KEY_W-1:0] K_STAT_A  = 15'h1000;
    localparam logic [KEY_W-1:0] K_STAT_B  = 15'h2000;
    localparam logic [KEY_W-1:0] K_STAT_C  = 15'h3000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE          = 6'd0;
    localparam logic [CMD_W-1:0] CMD_TOP           = 6'd1;
    localparam logic [CMD_W-1:0] CMD_BOTTOM        = 6'd2;
    localparam logic [CMD_W-1:0] CMD_LINE_UP       = 6'd3;
    localparam logic [CMD_W-1:0] CMD_WIN_UP        = 6'd4;
    localparam logic [CMD_W-1:0] CMD_LINE_DOWN     = 6'd5;
    localparam logic [CMD_W-1:0] CMD_WIN_DOWN      = 6'd6;
    localparam logic [CMD_W-1:0] CMD_FULL_LEFT     = 6'd7;
    localparam logic [CMD_W-1:0] CMD_LINE_BEGIN    = 6'd8;
    localparam logic [CMD_W-1:0] CMD_HALF_LEFT     = 6'd9;
    localparam logic [CMD_W-1:0] CMD_CHAR_LEFT     = 6'd10;
    localparam logic [CMD_W-1:0] CMD_FULL_RIGHT    = 6'd11;
    localparam logic [CMD_W-1:0] CMD_LINE_END      = 6'd12;
    localparam logic [CMD_W-1:0] CMD_CHAR_RIGHT    = 6'd13;
    localparam logic [CMD_W-1:0] CMD_HALF_RIGHT    = 6'd14;
    localparam logic [CMD_W-1:0] CMD_PREV_DIFF     = 6'd15;
    localparam logic [CMD_W-1:0] CMD_NEXT_DIFF     = 6'd16;
    localparam logic [CMD_W-1:0] CMD_HUSH_SPEECH   = 6'd17;
    localparam logic [CMD_W-1:0] CMD_SAY           = 6'd18;
    localparam logic [CMD_W-1:0] CMD_CONFIG_MENU   = 6'd19;
    localparam logic [CMD_W-1:0] CMD_HOLD_VIEW     = 6'd20;
    localparam logic [CMD_W-1:0] CMD_STATUS_VIEW   = 6'd21;
    localparam logic [CMD_W-1:0] CMD_CAP_BLINK     = 6'd22;
    localparam logic [CMD_W-1:0] CMD_CSR_VISIBLE   = 6'd23;
    localparam logic [CMD_W-1:0] CMD_CSR_BLINK     = 6'd24;
    localparam logic [CMD_W-1:0] CMD_SIX_DOTS      = 6'd25;
    localparam logic [CMD_W-1:0] CMD_CSR_SIZE      = 6'd26;
    localparam logic [CMD_W-1:0] CMD_SLIDE_WIN     = 6'd27;
    localparam logic [CMD_W-1:0] CMD_CUT_BEGIN     = 6'd28;
    localparam logic [CMD_W-1:0] CMD_CLIP_FINISH   = 6'd29;
    localparam logic [CMD_W-1:0] CMD_ROUTE         = 6'd30;
    localparam logic [CMD_W-1:0] CMD_BLOCK_BEGIN   = 6'd31;
    localparam logic [CMD_W-1:0] CMD_BLOCK_END     = 6'd32;
    localparam logic [CMD_W-1:0] CMD_INSERT_CLIP   = 6'd33;
    localparam logic [CMD_W-1:0] CMD_REL_TOP_LEFT  = 6'd34;
    localparam logic [CMD_W-1:0] CMD_REL_HOME      = 6'd35;
    localparam logic [CMD_W-1:0] CMD_REL_HELP      = 6'd36;
    localparam logic [CMD_W-1:0] CMD_REL_DISP_MODE = 6'd37;
    localparam logic [CMD_W-1:0] CMD_REL_CSR_TRACK = 6'd38;

    typedef struct packed {
        logic [GRP_W-1:0]  pending_group;
        logic [KEY_W-1:0]  held_keys;
        logic [KEY_W-1:0]  last_chord;
        logic [KEY_W-1:0]  released_chord;
        logic [POS_W-1:0]  routing_position;
        logic              repeat_armed;
        logic [TICK_W-1:0] delay_count;
        logic [TICK_W-1:0] interval_count;
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] route_position;
        logic             rewrite_request;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             repeatable;
    } press_t;

    function automatic logic [KEY_W-1:0] op_key_bit(input logic [3:0] idx);
        logic [KEY_W-1:0] k;
        case (idx)
            4'd0:    k = K_PROG;
            4'd1:    k = K_HOME;
            4'd2:    k = K_CURSOR;
            4'd3:    k = K_UP;
            4'd4:    k = K_LEFT;
            4'd5:    k = K_RIGHT;
            4'd6:    k = K_DOWN;
            4'd7:    k = K_CURSOR2;
            4'd8:    k = K_HOME2;
            4'd9:    k = K_PROG2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic press_t press_lookup(input logic [KEY_W-1:0] chord);
        press_t p;
        p.command    = CMD_NONE;
        p.repeatable = 1'b0;
        case (chord)
            K_HOME | K_UP:             p.command = CMD_TOP;
            K_HOME | K_DOWN:           p.command = CMD_BOTTOM;
            K_UP:                      p = '{CMD_LINE_UP, 1'b1};
            K_CURSOR | K_UP:           p = '{CMD_WIN_UP, 1'b1};
            K_DOWN:                    p = '{CMD_LINE_DOWN, 1'b1};
            K_CURSOR | K_DOWN:         p = '{CMD_WIN_DOWN, 1'b1};
            K_LEFT:                    p.command = CMD_FULL_LEFT;
            K_HOME | K_LEFT:           p.command = CMD_LINE_BEGIN;
            K_CURSOR | K_LEFT:         p.command = CMD_HALF_LEFT;
            K_PROG | K_LEFT:           p = '{CMD_CHAR_LEFT, 1'b1};
            K_RIGHT:                   p.command = CMD_FULL_RIGHT;
            K_HOME | K_RIGHT:          p.command = CMD_LINE_END;
            K_PROG | K_RIGHT:          p = '{CMD_CHAR_RIGHT, 1'b1};
            K_CURSOR | K_RIGHT:        p.command = CMD_HALF_RIGHT;
            K_HOME | K_CURSOR | K_UP:    p.command = CMD_PREV_DIFF;
            K_HOME | K_CURSOR | K_DOWN:  p.command = CMD_NEXT_DIFF;
            K_HOME | K_CURSOR | K_LEFT:  p.command = CMD_HUSH_SPEECH;
            K_HOME | K_CURSOR | K_RIGHT: p.command = CMD_SAY;
            K_PROG | K_CURSOR:         p.command = CMD_CONFIG_MENU;
            K_PROG | K_DOWN:           p.command = CMD_HOLD_VIEW;
            K_PROG | K_UP:             p.command = CMD_STATUS_VIEW;
            K_STAT_A:                  p.command = CMD_CAP_BLINK;
            K_STAT_B:                  p.command = CMD_CSR_VISIBLE;
            K_STAT_C:                  p.command = CMD_CSR_BLINK;
            K_CURSOR | K_STAT_A:       p.command = CMD_SIX_DOTS;
            K_CURSOR | K_STAT_B:       p.command = CMD_CSR_SIZE;
            K_CURSOR | K_STAT_C:       p.command = CMD_SLIDE_WIN;
            K_PROG | K_HOME | K_LEFT:  p.command = CMD_CUT_BEGIN;
            K_PROG | K_HOME | K_RIGHT: p.command = CMD_CLIP_FINISH;
            K_ROUTE:                   p.command = CMD_ROUTE;
            K_PROG | K_ROUTE:          p.command = CMD_BLOCK_BEGIN;
            K_HOME | K_ROUTE:          p.command = CMD_BLOCK_END;
            K_PROG | K_HOME | K_DOWN:  p.command = CMD_INSERT_CLIP;
            default:                   p.command = CMD_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [CMD_W-1:0] release_lookup(input logic [KEY_W-1:0] chord);
        logic [CMD_W-1:0] c;
        case (chord)
            K_HOME:            c = CMD_REL_TOP_LEFT;
            K_CURSOR:          c = CMD_REL_HOME;
            K_PROG:            c = CMD_REL_HELP;
            K_PROG | K_HOME:   c = CMD_REL_DISP_MODE;
            K_HOME | K_CURSOR: c = CMD_REL_CSR_TRACK;
            default:           c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bkcd_step.sv
`default_nettype none

module bkcd_step (
    input  wire bkcd_pkg::state_t             cur,
    input  wire logic [bkcd_pkg::TICK_W-1:0]  delay_ticks,
    input  wire logic [bkcd_pkg::TICK_W-1:0]  interval_ticks,
    input  wire logic                         kind,
    input  wire logic [7:0]                   rx_byte,
    output bkcd_pkg::state_t                  nxt,
    output bkcd_pkg::result_t                 res
);

    logic                       evt;
    logic [bkcd_pkg::KEY_W-1:0] held;
    logic [bkcd_pkg::KEY_W-1:0] last;
    logic [bkcd_pkg::KEY_W-1:0] stat_bits;
    bkcd_pkg::press_t           prs;

    // status key n (0..5) encodes as n+1 in bits 14:12
    assign stat_bits = {rx_byte[2:0] + 3'd1, 12'h000};

    always_comb begin
        nxt  = cur;
        res  = '0;
        evt  = 1'b0;
        held = cur.held_keys;
        last = cur.last_chord;

        if (!kind) begin
            case (cur.pending_group)
                bkcd_pkg::GRP_OP: begin
                    if (rx_byte <= bkcd_pkg::BYTE_OP_MAKE_MAX) begin
                        held = held | bkcd_pkg::op_key_bit(rx_byte[3:0]);
                    end else if (rx_byte >= bkcd_pkg::BYTE_ST_MAKE_MIN &&
                                 rx_byte <= bkcd_pkg::BYTE_ST_MAKE_MAX) begin
                        held = held | stat_bits;
                    end else if (rx_byte >= bkcd_pkg::BYTE_OP_BREAK_MIN &&
                                 rx_byte <= bkcd_pkg::BYTE_OP_BREAK_MAX) begin
                        held = held & ~bkcd_pkg::op_key_bit(rx_byte[3:0]);
                    end else if (rx_byte >= bkcd_pkg::BYTE_ST_BREAK_MIN &&
                                 rx_byte <= bkcd_pkg::BYTE_ST_BREAK_MAX) begin
                        held = held & ~stat_bits;
                    end else begin
                        held = '0;
                    end
                    nxt.pending_group = bkcd_pkg::GRP_NONE;
                    evt = 1'b1;
                end
                bkcd_pkg::GRP_ROUTE: begin
                    if (rx_byte <= bkcd_pkg::BYTE_ROUTE_MAX) begin
                        nxt.routing_position = rx_byte[bkcd_pkg::POS_W-1:0];
                        held = held | bkcd_pkg::K_ROUTE;
                    end else begin
                        held = held & ~bkcd_pkg::K_ROUTE;
                    end
                    nxt.pending_group = bkcd_pkg::GRP_NONE;
                    evt = 1'b1;
                end
                default: begin
                    if (rx_byte == bkcd_pkg::BYTE_GRP_OP) begin
                        nxt.pending_group = bkcd_pkg::GRP_OP;
                    end else if (rx_byte == bkcd_pkg::BYTE_GRP_ROUTE) begin
                        nxt.pending_group = bkcd_pkg::GRP_ROUTE;
                    end else begin
                        held = '0;
                        res.rewrite_request = 1'b1;
                        nxt.pending_group = bkcd_pkg::GRP_NONE;
                    end
                end
            endcase
            if (evt) begin
                nxt.repeat_armed   = 1'b0;
                nxt.delay_count    = '0;
                nxt.interval_count = '0;
            end
        end else if (cur.repeat_armed) begin
            if (cur.delay_count < delay_ticks) begin
                nxt.delay_count = cur.delay_count + 8'd1;
            end else if (cur.interval_count < interval_ticks) begin
                nxt.interval_count = cur.interval_count + 8'd1;
            end else begin
                // typematic repeat: replay the chord as a fresh press
                held = cur.last_chord;
                last = '0;
                nxt.interval_count = '0;
                evt = 1'b1;
            end
        end

        nxt.held_keys  = held;
        nxt.last_chord = last;
        prs            = bkcd_pkg::press_lookup(held);

        if (evt) begin
            if (held > last) begin
                nxt.last_chord     = held;
                nxt.released_chord = '0;
                res.command        = prs.command;
                if (prs.repeatable) begin
                    nxt.repeat_armed = 1'b1;
                end
                if (prs.command == bkcd_pkg::CMD_ROUTE ||
                    prs.command == bkcd_pkg::CMD_BLOCK_BEGIN ||
                    prs.command == bkcd_pkg::CMD_BLOCK_END) begin
                    res.route_position = nxt.routing_position;
                end
            end else begin
                // only the first release of a chord reports
                if (cur.released_chord == '0) begin
                    nxt.released_chord = last;
                    res.command = bkcd_pkg::release_lookup(last);
                    if (res.command == bkcd_pkg::CMD_REL_HOME) begin
                        res.rewrite_request = 1'b1;
                    end
                end
                nxt.last_chord = held;
                if (held == '0) begin
                    nxt.released_chord = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/braille_key_chord_decoder_top.sv
`default_nettype none

// The result register loads on an accepted input beat, so its result beat follows in the next cycle.
// Throughput: one beat per cycle; the result register frees itself as it is taken,
// so a new input is taken whenever the result register is empty or being read.
// Reset (aresetn low, synchronous): key state and counters clear, no group pending,
// no result held, delay/interval registers return to 10 and 2 ticks.

module braille_key_chord_decoder_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [bkcd_pkg::TICK_W-1:0]  cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic [7:0]                   s_rx_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [bkcd_pkg::CMD_W-1:0]        m_command,
    output logic [bkcd_pkg::POS_W-1:0]        m_route_position,
    output logic                              m_rewrite_request
);

    bkcd_pkg::state_t  state_reg;
    bkcd_pkg::state_t  state_next;
    bkcd_pkg::result_t res_reg;
    bkcd_pkg::result_t res_next;
    logic              m_valid_reg;
    logic [bkcd_pkg::TICK_W-1:0] delay_ticks_reg;
    logic [bkcd_pkg::TICK_W-1:0] interval_ticks_reg;
    logic              in_beat;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    bkcd_step u_step (
        .cur            (state_reg),
        .delay_ticks    (delay_ticks_reg),
        .interval_ticks (interval_ticks_reg),
        .kind           (s_kind),
        .rx_byte        (s_rx_byte),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg    <= bkcd_pkg::DELAY_RESET;
            interval_ticks_reg <= bkcd_pkg::INTERVAL_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                bkcd_pkg::CFG_DELAY:    delay_ticks_reg    <= cfg_wdata;
                bkcd_pkg::CFG_INTERVAL: interval_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                state_reg <= state_next;
            end
            if (in_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_command         = res_reg.command;
    assign m_route_position  = res_reg.route_position;
    assign m_rewrite_request = res_reg.rewrite_request;

    a_result_follows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> m_valid)
        else $error("input beat produced no result");

    a_pos_only_routing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command != bkcd_pkg::CMD_ROUTE &&
         m_command != bkcd_pkg::CMD_BLOCK_BEGIN &&
         m_command != bkcd_pkg::CMD_BLOCK_END) |-> m_route_position == '0)
        else $error("routing position on non-routing command");

    a_home_release_rewrites: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == bkcd_pkg::CMD_REL_HOME) |-> m_rewrite_request)
        else $error("cursor release without rewrite");

    a_unused_key_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_keys[11] == 1'b0 && state_reg.last_chord[11] == 1'b0)
        else $error("unused key bit set");

    a_group_code: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending_group == bkcd_pkg::GRP_NONE ||
        state_reg.pending_group == bkcd_pkg::GRP_OP ||
        state_reg.pending_group == bkcd_pkg::GRP_ROUTE)
        else $error("bad pending group");

    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

### bench/chord_decode_checker.sv
`default_nettype none

module chord_decode_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [bkcd_pkg::TICK_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic                        s_kind,
    input  wire logic [7:0]                  s_rx_byte,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [bkcd_pkg::CMD_W-1:0]  m_command,
    input  wire logic [bkcd_pkg::POS_W-1:0]  m_route_position,
    input  wire logic                        m_rewrite_request,
    output int                               fail_count,
    output int                               outstanding,
    output int                               results_seen,
    output int                               repeat_count,
    output int                               release_count
);

    localparam logic [bkcd_pkg::KEY_W-1:0] K_UP      = bkcd_pkg::K_UP;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_CURSOR  = bkcd_pkg::K_CURSOR;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_HOME    = bkcd_pkg::K_HOME;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_PROG    = bkcd_pkg::K_PROG;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_LEFT    = bkcd_pkg::K_LEFT;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_RIGHT   = bkcd_pkg::K_RIGHT;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_DOWN    = bkcd_pkg::K_DOWN;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_CURSOR2 = bkcd_pkg::K_CURSOR2;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_HOME2   = bkcd_pkg::K_HOME2;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_PROG2   = bkcd_pkg::K_PROG2;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_ROUTE   = bkcd_pkg::K_ROUTE;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_STAT_A  = bkcd_pkg::K_STAT_A;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_STAT_B  = bkcd_pkg::K_STAT_B;
    localparam logic [bkcd_pkg::KEY_W-1:0] K_STAT_C  = bkcd_pkg::K_STAT_C;

    // decoder state as predicted
    logic [bkcd_pkg::GRP_W-1:0]  group;
    logic [bkcd_pkg::KEY_W-1:0]  held;
    logic [bkcd_pkg::KEY_W-1:0]  chord;
    logic [bkcd_pkg::KEY_W-1:0]  chord_at_release;
    logic [bkcd_pkg::POS_W-1:0]  route_pos;
    logic                        armed;
    logic [bkcd_pkg::TICK_W-1:0] delay_ticks;
    logic [bkcd_pkg::TICK_W-1:0] interval_ticks;
    logic [bkcd_pkg::TICK_W-1:0] cfg_delay;
    logic [bkcd_pkg::TICK_W-1:0] cfg_interval;

    bkcd_pkg::result_t due_results[$];

    function automatic logic [bkcd_pkg::KEY_W-1:0] op_key(input logic [3:0] n);
        logic [bkcd_pkg::KEY_W-1:0] k;
        case (n)
            4'd0:    k = K_PROG;
            4'd1:    k = K_HOME;
            4'd2:    k = K_CURSOR;
            4'd3:    k = K_UP;
            4'd4:    k = K_LEFT;
            4'd5:    k = K_RIGHT;
            4'd6:    k = K_DOWN;
            4'd7:    k = K_CURSOR2;
            4'd8:    k = K_HOME2;
            4'd9:    k = K_PROG2;
            default: k = '0;
        endcase
        return k;
    endfunction

    // status keys 0..5 carry the values 1..6 in bits 12..14
    function automatic logic [bkcd_pkg::KEY_W-1:0] status_keys(input logic [2:0] n);
        return {n + 3'd1, 12'd0};
    endfunction

    function automatic bkcd_pkg::result_t decode_beat(input logic is_tick,
                                                      input logic [7:0] b);
        bkcd_pkg::result_t r;
        logic              key_event;
        r = '0;
        key_event = 1'b0;
        if (!is_tick) begin
            case (group)
                bkcd_pkg::GRP_OP: begin
                    if (b <= bkcd_pkg::BYTE_OP_MAKE_MAX)
                        held = held | op_key(b[3:0]);
                    else if (b >= bkcd_pkg::BYTE_ST_MAKE_MIN &&
                             b <= bkcd_pkg::BYTE_ST_MAKE_MAX)
                        held = held | status_keys(b[2:0]);
                    else if (b >= bkcd_pkg::BYTE_OP_BREAK_MIN &&
                             b <= bkcd_pkg::BYTE_OP_BREAK_MAX)
                        held = held & ~op_key(b[3:0]);
                    else if (b >= bkcd_pkg::BYTE_ST_BREAK_MIN &&
                             b <= bkcd_pkg::BYTE_ST_BREAK_MAX)
                        held = held & ~status_keys(b[2:0]);
                    else
                        held = '0;
                    group = bkcd_pkg::GRP_NONE;
                    key_event = 1'b1;
                end
                bkcd_pkg::GRP_ROUTE: begin
                    if (b <= bkcd_pkg::BYTE_ROUTE_MAX) begin
                        route_pos = b[bkcd_pkg::POS_W-1:0];
                        held = held | K_ROUTE;
                    end else begin
                        held = held & ~K_ROUTE;
                    end
                    group = bkcd_pkg::GRP_NONE;
                    key_event = 1'b1;
                end
                default: begin
                    if (b == bkcd_pkg::BYTE_GRP_OP) begin
                        group = bkcd_pkg::GRP_OP;
                    end else if (b == bkcd_pkg::BYTE_GRP_ROUTE) begin
                        group = bkcd_pkg::GRP_ROUTE;
                    end else begin
                        held = '0;
                        r.rewrite_request = 1'b1;
                    end
                end
            endcase
            if (key_event) begin
                armed = 1'b0;
                delay_ticks = '0;
                interval_ticks = '0;
            end
        end else if (armed) begin
            if (delay_ticks < cfg_delay) begin
                delay_ticks = delay_ticks + 1'b1;
            end else if (interval_ticks < cfg_interval) begin
                interval_ticks = interval_ticks + 1'b1;
            end else begin
                // typematic repeat: replay the held chord as a fresh press
                held = chord;
                chord = '0;
                interval_ticks = '0;
                key_event = 1'b1;
                repeat_count++;
            end
        end

        if (key_event) begin
            if (held > chord) begin
                chord = held;
                chord_at_release = '0;
                case (held)
                    K_HOME | K_UP:               r.command = bkcd_pkg::CMD_TOP;
                    K_HOME | K_DOWN:             r.command = bkcd_pkg::CMD_BOTTOM;
                    K_UP:                        r.command = bkcd_pkg::CMD_LINE_UP;
                    K_CURSOR | K_UP:             r.command = bkcd_pkg::CMD_WIN_UP;
                    K_DOWN:                      r.command = bkcd_pkg::CMD_LINE_DOWN;
                    K_CURSOR | K_DOWN:           r.command = bkcd_pkg::CMD_WIN_DOWN;
                    K_LEFT:                      r.command = bkcd_pkg::CMD_FULL_LEFT;
                    K_HOME | K_LEFT:             r.command = bkcd_pkg::CMD_LINE_BEGIN;
                    K_CURSOR | K_LEFT:           r.command = bkcd_pkg::CMD_HALF_LEFT;
                    K_PROG | K_LEFT:             r.command = bkcd_pkg::CMD_CHAR_LEFT;
                    K_RIGHT:                     r.command = bkcd_pkg::CMD_FULL_RIGHT;
                    K_HOME | K_RIGHT:            r.command = bkcd_pkg::CMD_LINE_END;
                    K_PROG | K_RIGHT:            r.command = bkcd_pkg::CMD_CHAR_RIGHT;
                    K_CURSOR | K_RIGHT:          r.command = bkcd_pkg::CMD_HALF_RIGHT;
                    K_HOME | K_CURSOR | K_UP:    r.command = bkcd_pkg::CMD_PREV_DIFF;
                    K_HOME | K_CURSOR | K_DOWN:  r.command = bkcd_pkg::CMD_NEXT_DIFF;
                    K_HOME | K_CURSOR | K_LEFT:  r.command = bkcd_pkg::CMD_HUSH_SPEECH;
                    K_HOME | K_CURSOR | K_RIGHT: r.command = bkcd_pkg::CMD_SAY;
                    K_PROG | K_CURSOR:           r.command = bkcd_pkg::CMD_CONFIG_MENU;
                    K_PROG | K_DOWN:             r.command = bkcd_pkg::CMD_HOLD_VIEW;
                    K_PROG | K_UP:               r.command = bkcd_pkg::CMD_STATUS_VIEW;
                    K_STAT_A:                    r.command = bkcd_pkg::CMD_CAP_BLINK;
                    K_STAT_B:                    r.command = bkcd_pkg::CMD_CSR_VISIBLE;
                    K_STAT_C:                    r.command = bkcd_pkg::CMD_CSR_BLINK;
                    K_CURSOR | K_STAT_A:         r.command = bkcd_pkg::CMD_SIX_DOTS;
                    K_CURSOR | K_STAT_B:         r.command = bkcd_pkg::CMD_CSR_SIZE;
                    K_CURSOR | K_STAT_C:         r.command = bkcd_pkg::CMD_SLIDE_WIN;
                    K_PROG | K_HOME | K_LEFT:    r.command = bkcd_pkg::CMD_CUT_BEGIN;
                    K_PROG | K_HOME | K_RIGHT:   r.command = bkcd_pkg::CMD_CLIP_FINISH;
                    K_ROUTE:                     r.command = bkcd_pkg::CMD_ROUTE;
                    K_PROG | K_ROUTE:            r.command = bkcd_pkg::CMD_BLOCK_BEGIN;
                    K_HOME | K_ROUTE:            r.command = bkcd_pkg::CMD_BLOCK_END;
                    K_PROG | K_HOME | K_DOWN:    r.command = bkcd_pkg::CMD_INSERT_CLIP;
                    default:                     r.command = bkcd_pkg::CMD_NONE;
                endcase
                if (r.command == bkcd_pkg::CMD_LINE_UP ||
                    r.command == bkcd_pkg::CMD_WIN_UP ||
                    r.command == bkcd_pkg::CMD_LINE_DOWN ||
                    r.command == bkcd_pkg::CMD_WIN_DOWN ||
                    r.command == bkcd_pkg::CMD_CHAR_LEFT ||
                    r.command == bkcd_pkg::CMD_CHAR_RIGHT)
                    armed = 1'b1;
                if (r.command >= bkcd_pkg::CMD_ROUTE && r.command <= bkcd_pkg::CMD_BLOCK_END)
                    r.route_position = route_pos;
            end else begin
                // only the first release after a press yields a command
                if (chord_at_release == '0) begin
                    chord_at_release = chord;
                    case (chord)
                        K_HOME:            r.command = bkcd_pkg::CMD_REL_TOP_LEFT;
                        K_CURSOR:          r.command = bkcd_pkg::CMD_REL_HOME;
                        K_PROG:            r.command = bkcd_pkg::CMD_REL_HELP;
                        K_PROG | K_HOME:   r.command = bkcd_pkg::CMD_REL_DISP_MODE;
                        K_HOME | K_CURSOR: r.command = bkcd_pkg::CMD_REL_CSR_TRACK;
                        default:           r.command = bkcd_pkg::CMD_NONE;
                    endcase
                    if (r.command == bkcd_pkg::CMD_REL_HOME)
                        r.rewrite_request = 1'b1;
                    if (r.command != bkcd_pkg::CMD_NONE)
                        release_count++;
                end
                chord = held;
                if (held == '0)
                    chord_at_release = '0;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        bkcd_pkg::result_t want;
        if (!aresetn) begin
            group = bkcd_pkg::GRP_NONE;
            held = '0;
            chord = '0;
            chord_at_release = '0;
            route_pos = '0;
            armed = 1'b0;
            delay_ticks = '0;
            interval_ticks = '0;
            cfg_delay = bkcd_pkg::DELAY_RESET;
            cfg_interval = bkcd_pkg::INTERVAL_RESET;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == bkcd_pkg::CFG_DELAY)
                    cfg_delay = cfg_wdata;
                else
                    cfg_interval = cfg_wdata;
            end
            // result side first: a beat leaving now belongs to an earlier input
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: command %0d position %0d rewrite %0d",
                                 m_command, m_route_position, m_rewrite_request);
                end else begin
                    want = due_results.pop_front();
                    if (m_command !== want.command ||
                        m_route_position !== want.route_position ||
                        m_rewrite_request !== want.rewrite_request) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: expected cmd %0d pos %0d rw %0d, got %0d %0d %0d",
                                     results_seen, want.command, want.route_position,
                                     want.rewrite_request, m_command, m_route_position,
                                     m_rewrite_request);
                    end
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(decode_beat(s_kind, s_rx_byte));
        end
        outstanding = due_results.size();
    end

endmodule

`default_nettype wire

### bench/tb_braille_key_chord_decoder_top.sv
`default_nettype none

module tb_braille_key_chord_decoder_top;

    localparam int CYCLE_LIMIT = 200000;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic                        cfg_addr  = bkcd_pkg::CFG_DELAY;
    logic [bkcd_pkg::TICK_W-1:0] cfg_wdata = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic                        s_kind    = 1'b0;
    logic [7:0]                  s_rx_byte = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [bkcd_pkg::CMD_W-1:0]  m_command;
    logic [bkcd_pkg::POS_W-1:0]  m_route_position;
    logic                        m_rewrite_request;

    int fail_count;
    int outstanding;
    int results_seen;
    int repeat_count;
    int release_count;

    int        beats_sent = 0;
    int        cycles     = 0;
    logic      src_idle   = 1'b0;
    logic      snk_idle   = 1'b0;
    logic      hold_req   = 1'b0;
    logic [9:0] gen_held  = '0;

    braille_key_chord_decoder_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command         (m_command),
        .m_route_position  (m_route_position),
        .m_rewrite_request (m_rewrite_request)
    );

    chord_decode_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command         (m_command),
        .m_route_position  (m_route_position),
        .m_rewrite_request (m_rewrite_request),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .results_seen      (results_seen),
        .repeat_count      (repeat_count),
        .release_count     (release_count)
    );

    always #1 aclk = ~aclk;

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
        $display("braille_key_chord_decoder_top: mismatch");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (40) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (snk_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid stays up from one beat to the next unless a gap is inserted
    task automatic push_beat(input logic k, input logic [7:0] b);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= k;
        s_rx_byte <= b;
        beats_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic op_event(input logic [7:0] b);
        push_beat(1'b0, bkcd_pkg::BYTE_GRP_OP);
        push_beat(1'b0, b);
    endtask

    task automatic route_event(input logic [7:0] b);
        push_beat(1'b0, bkcd_pkg::BYTE_GRP_ROUTE);
        push_beat(1'b0, b);
    endtask

    task automatic ticks(input int n);
        repeat (n) push_beat(1'b1, 8'($urandom));
    endtask

    // whatever group is pending, this ends with an empty chord and a key event
    task automatic clear_keys();
        push_beat(1'b0, 8'hFF);
        op_event(8'hFF);
        gen_held = '0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_repeat(input logic [bkcd_pkg::TICK_W-1:0] dly,
                              input logic [bkcd_pkg::TICK_W-1:0] ivl);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= bkcd_pkg::CFG_DELAY;
        cfg_wdata <= dly;
        @(posedge aclk);
        cfg_addr  <= bkcd_pkg::CFG_INTERVAL;
        cfg_wdata <= ivl;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_gesture();
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 36) begin
            if ($urandom_range(0, 9) == 0) begin
                op_event(bkcd_pkg::BYTE_ST_MAKE_MIN + 8'($urandom_range(0, 5)));
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
                gen_held[n] = 1'b1;
                op_event(8'(n));
            end
        end else if (r < 64) begin
            if (gen_held != '0 && $urandom_range(0, 4) != 0) begin
                n = $urandom_range(0, 9);
                while (!gen_held[n]) n = $urandom_range(0, 9);
                gen_held[n] = 1'b0;
                op_event(bkcd_pkg::BYTE_OP_BREAK_MIN + 8'(n));
            end else if ($urandom_range(0, 3) == 0) begin
                op_event(bkcd_pkg::BYTE_ST_BREAK_MIN + 8'($urandom_range(0, 5)));
            end else begin
                n = $urandom_range(0, 9);
                gen_held[n] = 1'b0;
                op_event(bkcd_pkg::BYTE_OP_BREAK_MIN + 8'(n));
            end
        end else if (r < 72) begin
            if ($urandom_range(0, 3) != 0)
                route_event(8'($urandom_range(0, 95)));
            else
                route_event(8'($urandom_range(96, 255)));
        end else if (r < 88) begin
            ticks($urandom_range(1, 12));
        end else if (r < 92) begin
            // stray byte outside any group
            b = 8'($urandom);
            if (b == bkcd_pkg::BYTE_GRP_OP || b == bkcd_pkg::BYTE_GRP_ROUTE)
                b = b ^ 8'h80;
            gen_held = '0;
            push_beat(1'b0, b);
        end else if (r < 95) begin
            // operating group followed by a byte that is no key
            b = 8'($urandom);
            while (b <= bkcd_pkg::BYTE_OP_MAKE_MAX ||
                   (b >= bkcd_pkg::BYTE_ST_MAKE_MIN && b <= bkcd_pkg::BYTE_ST_MAKE_MAX) ||
                   (b >= bkcd_pkg::BYTE_OP_BREAK_MIN && b <= bkcd_pkg::BYTE_OP_BREAK_MAX) ||
                   (b >= bkcd_pkg::BYTE_ST_BREAK_MIN && b <= bkcd_pkg::BYTE_ST_BREAK_MAX))
                b = 8'($urandom);
            gen_held = '0;
            op_event(b);
        end else if (r < 97) begin
            // lone group byte: the next gesture is read through it
            push_beat(1'b0, ($urandom_range(0, 1) == 1) ? bkcd_pkg::BYTE_GRP_OP
                                                        : bkcd_pkg::BYTE_GRP_ROUTE);
        end else begin
            for (int i = 0; i < 10; i++)
                if (gen_held[i])
                    op_event(bkcd_pkg::BYTE_OP_BREAK_MIN + 8'(i));
            gen_held = '0;
        end
    endtask

    task automatic run_until(input int target);
        while (beats_sent < target) random_gesture();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats at reset settings
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'h00);
        op_event(8'h02);                  // cursor alone: no binding
        op_event(8'h82);                  // cursor release asks for a rewrite
        op_event(8'h03);                  // line up, arms typematic
        push_beat(1'b1, 8'hFF);
        push_beat(1'b1, 8'h00);
        op_event(8'h83);
        route_event(bkcd_pkg::BYTE_ROUTE_MAX);
        op_event(8'h00);                  // prog + routing: block begin at 95
        route_event(8'h60);
        op_event(bkcd_pkg::BYTE_OP_BREAK_MIN);
        op_event(bkcd_pkg::BYTE_ST_MAKE_MAX);
        op_event(bkcd_pkg::BYTE_ST_BREAK_MAX);

        src_idle = 1'b1;
        snk_idle = 1'b1;
        hold_req = 1'b1;
        run_until(220);

        set_repeat(8'd0, 8'd0);
        run_until(400);

        set_repeat(8'd255, 8'd1);
        clear_keys();
        op_event(8'h03);
        ticks(262);
        run_until(700);

        set_repeat(8'd1, 8'd255);
        clear_keys();
        op_event(8'h06);
        ticks(262);
        run_until(980);

        set_repeat(8'($urandom_range(2, 9)), 8'($urandom_range(0, 4)));
        src_idle = 1'b0;
        snk_idle = 1'b0;
        run_until(1050);

        settle();
        repeat (4) @(posedge aclk);
        $display("%0d input beats, %0d results compared, %0d auto-repeats, %0d release commands",
                 beats_sent, results_seen, repeat_count, release_count);
        $display("repeat settings: reset, 0/0, 255/1, 1/255 and a random pair; one long output stall");
        if (fail_count == 0)
            $display("braille_key_chord_decoder_top: match");
        else
            $display("braille_key_chord_decoder_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### braille_key_chord_decoder_top.f
hw/rtl/bkcd_pkg.sv
hw/rtl/bkcd_step.sv
hw/rtl/braille_key_chord_decoder_top.sv
bench/chord_decode_checker.sv
bench/tb_braille_key_chord_decoder_top.sv
